>>> sv/pcti_pkg.sv
// Shared types and constants of the camera projection texel index core.
package pcti_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	localparam int REG_COUNT = 8;
	localparam int CFG_IDX_W = 4;
	localparam int REG_W     = 64;
	localparam int POS_W     = 32;
	localparam int PROD_W    = 44;
	localparam int CLIP_W    = 46;
	localparam int NUM_W     = 47;
	localparam int IDX_W     = 20;

	localparam int SIZE_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int DQ       = $clog2(SIZE_MAX + 1);
	localparam int NW       = NUM_W + DQ;
	localparam int MUL_W    = (2 * DQ > IDX_W) ? 2 * DQ : IDX_W;
	localparam int LATENCY  = DQ + 5;

	localparam logic [REG_W-1:0] MAT_RESET [REG_COUNT] = '{
		64'h0000_0000_0010_0000, 64'h0, 64'h0010_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0010_0000, 64'h0, 64'h0010_0000_0000_0000
	};

	typedef logic [REG_COUNT-1:0][REG_W-1:0] mat_t;
	typedef logic signed [CLIP_W-1:0] clip_t;

	typedef struct packed {
		logic vld;
		logic cov;
	} ctl_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [NW-1:0] dsh;
		logic [DQ-1:0] q;
	} div_t;

endpackage

>>> sv/pcti_xform.sv
// Two-stage matrix transform: products in stage 1, row sums in stage 2.
module pcti_xform (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcti_pkg::mat_t                       mat,
	input  pcti_pkg::ctl_t                       ctl_in,
	input  logic signed [pcti_pkg::POS_W-1:0]    pos_x,
	input  logic signed [pcti_pkg::POS_W-1:0]    pos_y,
	input  logic signed [pcti_pkg::POS_W-1:0]    pos_z,
	output pcti_pkg::ctl_t                       ctl_s2,
	output pcti_pkg::clip_t                      clip_s2 [4]
);

	logic signed [31:0] ent [4][4];
	logic signed [31:0] pos [3];
	logic signed [63:0] full [4][3];
	logic signed [pcti_pkg::PROD_W-1:0] prod_s1 [4][4];
	pcti_pkg::ctl_t ctl_s1;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (r[0])
					ent[r][c] = mat[c * 2 + r / 2][63:32];
				else
					ent[r][c] = mat[c * 2 + r / 2][31:0];
			end
		end
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 3; c++)
				full[r][c] = ent[r][c] * pos[c];
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++)
				prod_s1[r][c] <= full[r][c][63:20];
			// homogeneous 1.0: entry * 2^16 / 2^20, floor
			prod_s1[r][3] <= {{16{ent[r][3][31]}}, ent[r][3][31:4]};
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++)
			clip_s2[r] <= {{2{prod_s1[r][0][43]}}, prod_s1[r][0]}
				+ {{2{prod_s1[r][1][43]}}, prod_s1[r][1]}
				+ {{2{prod_s1[r][2][43]}}, prod_s1[r][2]}
				+ {{2{prod_s1[r][3][43]}}, prod_s1[r][3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

>>> sv/pcti_div_step.sv
// One registered restoring-division step: one quotient bit.
module pcti_div_step (
	input  logic           clk,
	input  pcti_pkg::div_t d_in,
	output pcti_pkg::div_t d_s
);

	logic ge;

	assign ge = d_in.rem >= d_in.dsh;

	always_ff @(posedge clk) begin
		d_s.rem <= ge ? d_in.rem - d_in.dsh : d_in.rem;
		d_s.dsh <= d_in.dsh >> 1;
		d_s.q   <= {d_in.q[pcti_pkg::DQ-2:0], ge};
	end

endmodule

>>> sv/camera_projection_texel_index_core.sv
// Top level: config registers, clip test, pixel dividers and index output.
// Throughput: one item per cycle; busy is always low, nothing stalls.
// Stages: 2 transform, 1 clip test, 1 size scale, DQ divider bits, 1 index.
// Reset: async active-low; matrix returns to identity, pipeline valids clear.
// The receiver cannot stall: done pulses for exactly one cycle per item.
module camera_projection_texel_index_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  covered,
	input  logic signed [pcti_pkg::POS_W-1:0]     pos_x,
	input  logic signed [pcti_pkg::POS_W-1:0]     pos_y,
	input  logic signed [pcti_pkg::POS_W-1:0]     pos_z,
	output logic                                  done,
	output logic                                  hit,
	output logic [pcti_pkg::IDX_W-1:0]            texel_index,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pcti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcti_pkg::REG_W-1:0]            cfg_data
);

	localparam int DQ = pcti_pkg::DQ;
	localparam int NW = pcti_pkg::NW;

	// matrix registers; writes past the list are dropped
	pcti_pkg::mat_t mat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcti_pkg::REG_COUNT; i++)
				mat_q[i] <= pcti_pkg::MAT_RESET[i];
		end else if (cfg_valid && cfg_index < pcti_pkg::CFG_IDX_W'(pcti_pkg::REG_COUNT)) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// stages 1-2: clip coordinates
	pcti_pkg::ctl_t  ctl_in, ctl_s2;
	pcti_pkg::clip_t clip_s2 [4];

	assign ctl_in.vld = start && !busy;
	assign ctl_in.cov = covered;

	pcti_xform u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_q),
		.ctl_in (ctl_in),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.ctl_s2 (ctl_s2),
		.clip_s2(clip_s2)
	);

	// stage 3: clip test, numerators x+w, y+w and denominator 2w
	logic signed [pcti_pkg::NUM_W-1:0] x_e, y_e, z_e, w_e, nw_e;
	logic in_clip;
	logic vld_s3, hit_s3;
	logic [pcti_pkg::NUM_W-1:0] numx_s3, numy_s3, den_s3;

	always_comb begin
		x_e  = {clip_s2[0][pcti_pkg::CLIP_W-1], clip_s2[0]};
		y_e  = {clip_s2[1][pcti_pkg::CLIP_W-1], clip_s2[1]};
		z_e  = {clip_s2[2][pcti_pkg::CLIP_W-1], clip_s2[2]};
		w_e  = {clip_s2[3][pcti_pkg::CLIP_W-1], clip_s2[3]};
		nw_e = -w_e;
		in_clip = (w_e > 0) && (x_e >= nw_e) && (x_e <= w_e) && (y_e >= nw_e)
			&& (y_e <= w_e) && (z_e >= nw_e) && (z_e <= w_e);
	end

	always_ff @(posedge clk) begin
		numx_s3 <= x_e + w_e;
		numy_s3 <= y_e + w_e;
		den_s3  <= w_e <<< 1;
		hit_s3  <= ctl_s2.cov && in_clip;
	end

	// stage 4: scale numerators by image size
	logic vld_s4, hit_s4;
	logic [NW-1:0] sclx_s4, scly_s4, den_s4;

	always_ff @(posedge clk) begin
		sclx_s4 <= NW'(numx_s3) * NW'(pcti_pkg::IMAGE_WIDTH);
		scly_s4 <= NW'(numy_s3) * NW'(pcti_pkg::IMAGE_HEIGHT);
		den_s4  <= NW'(den_s3);
		hit_s4  <= hit_s3;
	end

	// divider stages, one quotient bit each, x and y lanes in parallel
	pcti_pkg::div_t divx [DQ+1];
	pcti_pkg::div_t divy [DQ+1];
	logic vld_dv_s [DQ+1];
	logic hit_dv_s [DQ+1];

	assign divx[0].rem = sclx_s4;
	assign divx[0].dsh = den_s4 << (DQ - 1);
	assign divx[0].q   = '0;
	assign divy[0].rem = scly_s4;
	assign divy[0].dsh = den_s4 << (DQ - 1);
	assign divy[0].q   = '0;
	assign vld_dv_s[0] = vld_s4;
	assign hit_dv_s[0] = hit_s4;

	for (genvar k = 0; k < DQ; k++) begin : g_div
		pcti_div_step u_dx (.clk(clk), .d_in(divx[k]), .d_s(divx[k+1]));
		pcti_div_step u_dy (.clk(clk), .d_in(divy[k]), .d_s(divy[k+1]));
		always_ff @(posedge clk) begin
			hit_dv_s[k+1] <= hit_dv_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_dv_s[k+1] <= 1'b0;
			else
				vld_dv_s[k+1] <= vld_dv_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= ctl_s2.vld;
			vld_s4 <= vld_s3;
		end
	end

	// output stage: clamp to last column/row, flip rows, build index
	logic [DQ-1:0] qx, qy, px, py, row;
	logic [pcti_pkg::MUL_W-1:0] idx;

	always_comb begin
		qx  = divx[DQ].q;
		qy  = divy[DQ].q;
		px  = (qx > DQ'(pcti_pkg::IMAGE_WIDTH - 1))  ? DQ'(pcti_pkg::IMAGE_WIDTH - 1)  : qx;
		py  = (qy > DQ'(pcti_pkg::IMAGE_HEIGHT - 1)) ? DQ'(pcti_pkg::IMAGE_HEIGHT - 1) : qy;
		row = DQ'(pcti_pkg::IMAGE_HEIGHT - 1) - py;
		idx = pcti_pkg::MUL_W'(row) * pcti_pkg::MUL_W'(pcti_pkg::IMAGE_WIDTH)
			+ pcti_pkg::MUL_W'(px);
	end

	always_ff @(posedge clk) begin
		hit         <= hit_dv_s[DQ];
		texel_index <= hit_dv_s[DQ] ? idx[pcti_pkg::IDX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_dv_s[DQ];
	end

	// checks
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> texel_index == '0)
		else $error("miss with nonzero index");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(pcti_pkg::LATENCY) done)
		else $error("result missing at fixed latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(pcti_pkg::LATENCY) !done)
		else $error("result without an accepted item");

endmodule
